// ===== rtl/assert_macros.svh =====
// Assertion macros for the record index block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a condition in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/tsri_pkg.sv =====
// Shared types and constants for the timestamp sorted record index.
// No dependencies.
package tsri_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam int unsigned ENTRY_BYTES_DEF = 24;
  localparam logic [15:0] BODY_RESET      = 16'd4072;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0]  REG_BODY = 3'd0;

  localparam logic signed [63:0] TS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] TS_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECODE = 8'b0000_0010,
    ST_SEARCH = 8'b0000_0100,
    ST_CMP    = 8'b0000_1000,
    ST_SHIFT  = 8'b0001_0000,
    ST_INSERT = 8'b0010_0000,
    ST_READ   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic capture;
    logic decode;
    logic search_issue;
    logic search_cmp;
    logic shift_start;
    logic shift_step;
    logic insert;
    logic read_issue;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       fits;
    logic       rd_ok;
    logic       cnt_zero;
    logic       shift_needed;
    logic       ptr_at_lo;
  } dp_stat_t;

  typedef struct packed {
    logic [63:0] ts;
    logic [15:0] offset;
    logic [15:0] size;
  } entry_t;

endpackage

// ===== rtl/timestamp_sorted_record_index.sv =====
// Top level of the timestamp sorted record index: APB register and channels.
// Depends on tsri_pkg, tsri_ctrl, tsri_dp and assert_macros.svh.
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------
//   input   | in_valid_i / in_ready_o    | cmd, timestamp, payload_bytes, number
//   output  | out_valid_o / out_ready_i  | accepted .. entry_size
//   config  | psel, penable, pwrite      | paddr, pwdata, prdata (body_bytes)
//
// One word at a time. A clear, a rejected add and a bad read go from decode straight to done;
// a read adds one memory read. An add searches, then shifts when later entries must move, then
// inserts; the search takes one memory read and compare per search and compare state pair, the
// shift one entry per cycle through the single index memory.
// Reset empties the block at once; a stalled output holds the next result.
`include "assert_macros.svh"
module timestamp_sorted_record_index #(
  parameter int unsigned MAX_ENTRIES = tsri_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned ENTRY_BYTES = tsri_pkg::ENTRY_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [63:0] timestamp_i,
  input  logic [15:0]        payload_bytes_i,
  input  logic [7:0]         entry_number_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic [15:0]        payload_offset_o,
  output logic [7:0]         insert_position_o,
  output logic [8:0]         record_count_o,
  output logic signed [63:0] earliest_time_o,
  output logic signed [63:0] latest_time_o,
  output logic signed [63:0] entry_time_o,
  output logic [15:0]        entry_offset_o,
  output logic [15:0]        entry_size_o
);

  tsri_pkg::dp_cmd_t  dp_cmd;
  tsri_pkg::dp_stat_t dp_stat;
  logic        cfg_we;
  logic [15:0] body;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == tsri_pkg::REG_BODY);
  assign prdata = (paddr == tsri_pkg::REG_BODY) ? {16'd0, body} : 32'd0;

  tsri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  tsri_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ENTRY_BYTES (ENTRY_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .cfg_we_i          (cfg_we),
    .cfg_body_i        (pwdata[15:0]),
    .body_o            (body),
    .cmd_in_i          (cmd_i),
    .timestamp_i       (timestamp_i),
    .payload_bytes_i   (payload_bytes_i),
    .entry_number_i    (entry_number_i),
    .accepted_o        (accepted_o),
    .payload_offset_o  (payload_offset_o),
    .insert_position_o (insert_position_o),
    .record_count_o    (record_count_o),
    .earliest_time_o   (earliest_time_o),
    .latest_time_o     (latest_time_o),
    .entry_time_o      (entry_time_o),
    .entry_offset_o    (entry_offset_o),
    .entry_size_o      (entry_size_o)
  );

  `ASSERT_CLK(a_count_bound, out_valid_o |-> (32'(record_count_o) <= MAX_ENTRIES), "count over capacity")
  `ASSERT_NEXT(a_one_word, in_valid_i && in_ready_o, !in_ready_o, "second word taken while busy")
  `ASSERT_CLK(a_bounds_order, out_valid_o && accepted_o |-> earliest_time_o <= latest_time_o, "bounds out of order")

endmodule

// ===== rtl/tsri_ctrl.sv =====
// Sequencer for the record index: search, shift, insert and read steps.
// Depends on tsri_pkg; drives tsri_dp through command and status structs.
module tsri_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tsri_pkg::dp_stat_t stat_i,
  output tsri_pkg::dp_cmd_t  cmd_o
);

  tsri_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    case (state_q)
      tsri_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = tsri_pkg::ST_DECODE;
        end
      end
      tsri_pkg::ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = tsri_pkg::ST_DONE;
        if (stat_i.cmd == tsri_pkg::CMD_ADD && stat_i.fits) begin
          state_d = tsri_pkg::ST_SEARCH;
        end else if (stat_i.cmd == tsri_pkg::CMD_READ && stat_i.rd_ok) begin
          state_d = tsri_pkg::ST_READ;
        end
      end
      tsri_pkg::ST_SEARCH: begin
        if (stat_i.cnt_zero) begin
          cmd_o.shift_start = 1'b1;
          state_d = stat_i.shift_needed ? tsri_pkg::ST_SHIFT : tsri_pkg::ST_INSERT;
        end else begin
          cmd_o.search_issue = 1'b1;
          state_d            = tsri_pkg::ST_CMP;
        end
      end
      tsri_pkg::ST_CMP: begin
        cmd_o.search_cmp = 1'b1;
        state_d          = tsri_pkg::ST_SEARCH;
      end
      tsri_pkg::ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (stat_i.ptr_at_lo) begin
          state_d = tsri_pkg::ST_INSERT;
        end
      end
      tsri_pkg::ST_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = tsri_pkg::ST_DONE;
      end
      tsri_pkg::ST_READ: begin
        cmd_o.read_issue = 1'b1;
        state_d          = tsri_pkg::ST_DONE;
      end
      tsri_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = tsri_pkg::ST_IDLE;
        end
      end
      default: state_d = tsri_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsri_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/tsri_dp.sv =====
// Datapath for the record index: index memory, heads, bounds, result word.
// Depends on tsri_pkg; steered by tsri_ctrl.
module tsri_dp #(
  parameter int unsigned MAX_ENTRIES = tsri_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned ENTRY_BYTES = tsri_pkg::ENTRY_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsri_pkg::dp_cmd_t   cmd_i,
  output tsri_pkg::dp_stat_t  stat_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_body_i,
  output logic [15:0]         body_o,
  input  logic [1:0]          cmd_in_i,
  input  logic signed [63:0]  timestamp_i,
  input  logic [15:0]         payload_bytes_i,
  input  logic [7:0]          entry_number_i,
  output logic                accepted_o,
  output logic [15:0]         payload_offset_o,
  output logic [7:0]          insert_position_o,
  output logic [8:0]          record_count_o,
  output logic signed [63:0]  earliest_time_o,
  output logic signed [63:0]  latest_time_o,
  output logic signed [63:0]  entry_time_o,
  output logic [15:0]         entry_offset_o,
  output logic [15:0]         entry_size_o
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
  localparam logic [16:0]   EB      = 17'(ENTRY_BYTES);

  tsri_pkg::entry_t mem [MAX_ENTRIES];
  tsri_pkg::entry_t rd_data_q, wr_data;
  logic [AW-1:0] rd_addr, wr_addr, wr_addr_q;
  logic          re, we;

  logic [1:0]         cmd_q;
  logic signed [63:0] ts_q;
  logic [15:0]        size_q;
  logic [7:0]         num_q;

  logic [15:0]        body_q;
  logic [CW-1:0]      held_q, lo_q, cnt_q, ptr_q, half;
  logic [16:0]        phead_q, ihead_q, need, free_bytes;
  logic signed [63:0] min_q, max_q;
  logic               acc_q, pend_q;
  logic               fits, rd_ok;

  assign half       = cnt_q >> 1;
  assign need       = EB + 17'(size_q);
  assign free_bytes = phead_q - ihead_q;
  assign fits       = (held_q < MAX_CNT) && (need <= free_bytes);
  assign rd_ok      = 32'(num_q) < 32'(held_q);

  assign stat_o.cmd          = cmd_q;
  assign stat_o.fits         = fits;
  assign stat_o.rd_ok        = rd_ok;
  assign stat_o.cnt_zero     = (cnt_q == '0);
  assign stat_o.shift_needed = (held_q != lo_q);
  assign stat_o.ptr_at_lo    = (ptr_q == lo_q);
  assign body_o              = body_q;

  always_comb begin
    re      = 1'b0;
    we      = 1'b0;
    rd_addr = AW'(lo_q + half);
    wr_addr = wr_addr_q;
    wr_data = rd_data_q;
    if (cmd_i.search_issue) begin
      re = 1'b1;
    end
    if (cmd_i.read_issue) begin
      re      = 1'b1;
      rd_addr = AW'(num_q);
    end
    if (cmd_i.shift_step) begin
      we = pend_q;
      if (ptr_q != lo_q) begin
        re      = 1'b1;
        rd_addr = AW'(ptr_q - CW'(1));
      end
    end
    if (cmd_i.insert) begin
      we      = 1'b1;
      wr_addr = AW'(lo_q);
      wr_data = '{ts: ts_q, offset: 16'(phead_q - 17'(size_q)), size: size_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // hold the item and the search and shift pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= cmd_in_i;
      ts_q   <= timestamp_i;
      size_q <= payload_bytes_i;
      num_q  <= entry_number_i;
    end
    if (cmd_i.decode) begin
      lo_q  <= '0;
      cnt_q <= held_q;
    end
    if (cmd_i.search_cmp) begin
      if ($signed(rd_data_q.ts) < ts_q) begin
        lo_q  <= lo_q + half + CW'(1);
        cnt_q <= cnt_q - half - CW'(1);
      end else begin
        cnt_q <= half;
      end
    end
    if (cmd_i.shift_start) begin
      ptr_q <= held_q;
    end
    if (cmd_i.shift_step && ptr_q != lo_q) begin
      ptr_q     <= ptr_q - CW'(1);
      wr_addr_q <= AW'(ptr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_q  <= tsri_pkg::BODY_RESET;
      held_q  <= '0;
      ihead_q <= '0;
      phead_q <= 17'(tsri_pkg::BODY_RESET);
      min_q   <= tsri_pkg::TS_MAX;
      max_q   <= tsri_pkg::TS_MIN;
      acc_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        body_q  <= cfg_body_i;
        held_q  <= '0;
        ihead_q <= '0;
        phead_q <= 17'(cfg_body_i);
        min_q   <= tsri_pkg::TS_MAX;
        max_q   <= tsri_pkg::TS_MIN;
      end
      if (cmd_i.decode) begin
        acc_q <= (cmd_q == tsri_pkg::CMD_ADD && fits) ||
                 (cmd_q == tsri_pkg::CMD_READ && rd_ok);
        if (cmd_q == tsri_pkg::CMD_CLEAR) begin
          held_q  <= '0;
          ihead_q <= '0;
          phead_q <= 17'(body_q);
          min_q   <= tsri_pkg::TS_MAX;
          max_q   <= tsri_pkg::TS_MIN;
        end
      end
      if (cmd_i.shift_start) begin
        pend_q <= 1'b0;
      end
      if (cmd_i.shift_step) begin
        pend_q <= (ptr_q != lo_q);
      end
      if (cmd_i.insert) begin
        held_q  <= held_q + CW'(1);
        ihead_q <= ihead_q + EB;
        phead_q <= phead_q - 17'(size_q);
        if (ts_q < min_q) begin
          min_q <= ts_q;
        end
        if (ts_q > max_q) begin
          max_q <= ts_q;
        end
      end
    end
  end

  // load the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      accepted_o        <= acc_q;
      payload_offset_o  <= '0;
      insert_position_o <= '0;
      entry_time_o      <= '0;
      entry_offset_o    <= '0;
      entry_size_o      <= '0;
      record_count_o    <= 9'(held_q);
      earliest_time_o   <= min_q;
      latest_time_o     <= max_q;
      if (acc_q && cmd_q == tsri_pkg::CMD_ADD) begin
        payload_offset_o  <= phead_q[15:0];
        insert_position_o <= 8'(lo_q);
      end
      if (acc_q && cmd_q == tsri_pkg::CMD_READ) begin
        entry_time_o   <= $signed(rd_data_q.ts);
        entry_offset_o <= rd_data_q.offset;
        entry_size_o   <= rd_data_q.size;
      end
    end
  end

endmodule
